/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the stepper top-level design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define UDP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define UDP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");

`endif

/* design/udp_pkg.sv */
// ----------------------------------------------------------------------------
// udp_pkg
// types and constants of the up/down potentiometer tap stepper
// ----------------------------------------------------------------------------
package udp_pkg;

  localparam int TAP_LAST_DEF   = 255;
  localparam int COUNT_BITS_DEF = 16;
  localparam int TAP_RESET      = 128;

  localparam logic [7:0]  DESIRED_TAP_RST = 8'd128;
  localparam logic [15:0] DIR_SETUP_RST   = 16'd25;
  localparam logic [15:0] INC_LOW_RST     = 16'd50;
  localparam logic [15:0] INC_HIGH_RST    = 16'd25;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DESIRED_TAP = 2'd0,
    CFG_DIR_SETUP   = 2'd1,
    CFG_INC_LOW     = 2'd2,
    CFG_INC_HIGH    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DECIDE   = 3'd1,
    PH_SETUP    = 3'd2,
    PH_INC_LOW  = 3'd3,
    PH_INC_HIGH = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] inc_high_ticks;
    logic [15:0] inc_low_ticks;
    logic [15:0] dir_setup_ticks;
    logic [7:0]  desired_tap;
  } cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic [7:0] tap_position;
    logic       increment_level;
    logic       up_down_level;
    logic       chip_select_n;
  } res_t;

endpackage

/* design/udp_cfg.sv */
// ----------------------------------------------------------------------------
// udp_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module udp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [udp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [udp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output udp_pkg::cfg_t                      cfg
);
  import udp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.desired_tap     <= DESIRED_TAP_RST;
      cfg.dir_setup_ticks <= DIR_SETUP_RST;
      cfg.inc_low_ticks   <= INC_LOW_RST;
      cfg.inc_high_ticks  <= INC_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DESIRED_TAP: cfg.desired_tap     <= cfg_wdata[7:0];
        CFG_DIR_SETUP:   cfg.dir_setup_ticks <= cfg_wdata[15:0];
        CFG_INC_LOW:     cfg.inc_low_ticks   <= cfg_wdata[15:0];
        CFG_INC_HIGH:    cfg.inc_high_ticks  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/udp_core.sv */
// ----------------------------------------------------------------------------
// udp_core
// step sequencer state, next-state logic and registered result
// ----------------------------------------------------------------------------
module udp_core #(
  parameter int TAP_LAST   = udp_pkg::TAP_LAST_DEF,
  parameter int COUNT_BITS = udp_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  udp_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          tick,
  output logic          out_valid,
  input  logic          out_ready,
  output udp_pkg::res_t res
);
  import udp_pkg::*;

  localparam int TAP_BITS = $clog2(TAP_LAST + 1);
  localparam int CMP_BITS = (TAP_BITS > 8) ? TAP_BITS : 8;
  localparam int CW       = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int TAP_INIT = (TAP_RESET > TAP_LAST) ? TAP_LAST : TAP_RESET;

  localparam logic [TAP_BITS-1:0]   TAP_LAST_V = TAP_BITS'(TAP_LAST);
  localparam logic [CMP_BITS-1:0]   TAP_LAST_C = CMP_BITS'(TAP_LAST);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [TAP_BITS-1:0]   wiper_tap, wiper_tap_next;
  logic                  step_up, step_up_next;

  logic [CMP_BITS-1:0]   tgt, wiper_c;
  logic [COUNT_BITS:0]   cnt_inc;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [CW-1:0]         cnt_cmp;
  logic [15:0]           limit;
  logic                  cnt_done;
  logic                  stepping;
  logic                  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign tgt     = (CMP_BITS'(cfg.desired_tap) > TAP_LAST_C) ? TAP_LAST_C
                 : CMP_BITS'(cfg.desired_tap);
  assign wiper_c = CMP_BITS'(wiper_tap);

  // saturating tick counter and end-of-phase compare
  always_comb begin
    case (phase)
      PH_SETUP:    limit = cfg.dir_setup_ticks;
      PH_INC_LOW:  limit = cfg.inc_low_ticks;
      default:     limit = cfg.inc_high_ticks;
    endcase
    cnt_inc  = {1'b0, tick_count} + (COUNT_BITS+1)'(1);
    cnt_sat  = cnt_inc[COUNT_BITS] ? COUNT_MAX : cnt_inc[COUNT_BITS-1:0];
    cnt_cmp  = CW'(cnt_sat);
    cnt_done = (cnt_cmp >= CW'(limit)) || (cnt_sat == COUNT_MAX);
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    wiper_tap_next  = wiper_tap;
    step_up_next    = step_up;
    if (tick) begin
      case (phase)
        PH_DECIDE: begin
          if (tgt < wiper_c) begin
            step_up_next = 1'b0;
            phase_next   = PH_SETUP;
          end else if (tgt > wiper_c) begin
            step_up_next = 1'b1;
            phase_next   = PH_SETUP;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_SETUP, PH_INC_LOW, PH_INC_HIGH: begin
          tick_count_next = cnt_done ? '0 : cnt_sat;
          if (cnt_done) begin
            case (phase)
              PH_SETUP:   phase_next = PH_INC_LOW;
              PH_INC_LOW: phase_next = PH_INC_HIGH;
              default: begin
                phase_next = PH_DECIDE;
                if (step_up) begin
                  if (wiper_tap < TAP_LAST_V) wiper_tap_next = wiper_tap + TAP_BITS'(1);
                end else begin
                  if (wiper_tap != '0) wiper_tap_next = wiper_tap - TAP_BITS'(1);
                end
              end
            endcase
          end
        end
        default: begin
          tick_count_next = '0;
          phase_next      = (tgt != wiper_c) ? PH_DECIDE : PH_IDLE;
        end
      endcase
    end
  end

  assign stepping = (phase_next == PH_SETUP) || (phase_next == PH_INC_LOW)
                 || (phase_next == PH_INC_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      wiper_tap  <= TAP_BITS'(TAP_INIT);
      step_up    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        wiper_tap  <= wiper_tap_next;
        step_up    <= step_up_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.chip_select_n   <= !stepping;
      res.up_down_level   <= step_up_next;
      res.increment_level <= (phase_next != PH_INC_LOW);
      res.tap_position    <= 8'(wiper_tap_next);
      res.busy_res        <= stepping || (tgt != CMP_BITS'(wiper_tap_next));
    end
  end

endmodule

/* design/updown_pot_tap_stepper_top.sv */
// ----------------------------------------------------------------------------
// updown_pot_tap_stepper_top
// up/down plus increment pin sequencer for a stepping digital potentiometer
// ----------------------------------------------------------------------------
// One input transaction is one timer tick (tick = 1) or an idle slot
// (tick = 0); each produces exactly one result transaction carrying the pin
// levels and status after that tick. A transaction is taken every cycle:
// unless m_tready stalls a full result register: the sequencer update is a
// few compares and one counter increment between the state registers and
// the result register, so the result appears the cycle after acceptance and
// s_tready stays high whenever the result register is empty or being taken
// in the same cycle. Configuration writes take effect on the next cycle.
module updown_pot_tap_stepper_top #(
  parameter int TAP_LAST   = udp_pkg::TAP_LAST_DEF,
  parameter int COUNT_BITS = udp_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [udp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [udp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [0] tick
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] chip_select_n, [1] up_down_level, [2] increment_level,
  // [10:3] tap_position, [11] busy_res
  output logic [15:0]                       m_tdata
);
  import udp_pkg::*;

  `include "assert_macros.svh"

  cfg_t cfg;
  res_t res;

  udp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  udp_core #(
    .TAP_LAST   (TAP_LAST),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .tick      (s_tdata[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {4'b0000, res};

  `UDP_ASSERT(a_idle_not_busy, clk, rst, m_tvalid && !m_tdata[11] |-> m_tdata[0])
  `UDP_ASSERT(a_inc_low_selected, clk, rst, m_tvalid && !m_tdata[2] |-> !m_tdata[0])
  `UDP_ASSERT(a_accept_gives_result, clk, rst, s_tvalid && s_tready |=> m_tvalid)
  `UDP_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid)

endmodule

/* sim/updown_pot_tap_stepper_chk.sv */
// ----------------------------------------------------------------------------
// updown_pot_tap_stepper_chk
// pin sequence checker for the up/down potentiometer tap stepper
// ----------------------------------------------------------------------------
// Follows register writes and accepted tick transactions. For each tick it
// advances its own copy of the wiper sequencer and queues the pin levels
// the block should report. Every result transaction is compared field by
// field with the oldest queued levels. Any expectation still queued when
// end_check rises is also counted as a failure.
module updown_pot_tap_stepper_chk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [udp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [udp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [0] tick
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] chip_select_n, [1] up_down_level, [2] increment_level,
  // [10:3] tap_position, [11] busy_res
  input  logic [15:0]                       m_tdata,
  input  logic                              end_check,
  output int                                fail_count
);
  import udp_pkg::*;

  localparam int          TAP_TOP   = TAP_LAST_DEF;
  localparam logic [16:0] COUNT_TOP = (17'd1 << COUNT_BITS_DEF) - 17'd1;

  cfg_t        regs;
  phase_t      seq_phase;
  logic [15:0] tick_cnt;
  logic [7:0]  wiper;
  logic        step_up;
  res_t        pin_levels_q[$];
  bit          leftover_done;

  function automatic logic [7:0] target_tap();
    return (int'(regs.desired_tap) > TAP_TOP) ? 8'(TAP_TOP) : regs.desired_tap;
  endfunction

  // one tick of a timed phase, true once the phase has run its length
  function automatic bit phase_elapsed(input logic [15:0] limit);
    logic [16:0] nxt;
    nxt = {1'b0, tick_cnt} + 17'd1;
    if (nxt > COUNT_TOP) nxt = COUNT_TOP;
    if (nxt >= {1'b0, limit} || nxt == COUNT_TOP) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = nxt[15:0];
    return 1'b0;
  endfunction

  function automatic res_t step_wiper_sequencer(input logic tick);
    logic [7:0] tgt;
    logic       moving;
    res_t       pins;
    tgt = target_tap();
    if (tick) begin
      case (seq_phase)
        PH_DECIDE: begin
          if (tgt < wiper) begin
            step_up   = 1'b0;
            seq_phase = PH_SETUP;
          end else if (tgt > wiper) begin
            step_up   = 1'b1;
            seq_phase = PH_SETUP;
          end else begin
            seq_phase = PH_IDLE;
          end
        end
        PH_SETUP: begin
          if (phase_elapsed(regs.dir_setup_ticks)) seq_phase = PH_INC_LOW;
        end
        PH_INC_LOW: begin
          if (phase_elapsed(regs.inc_low_ticks)) seq_phase = PH_INC_HIGH;
        end
        PH_INC_HIGH: begin
          if (phase_elapsed(regs.inc_high_ticks)) begin
            if (step_up) begin
              if (int'(wiper) < TAP_TOP) wiper = wiper + 8'd1;
            end else if (wiper != 8'd0) begin
              wiper = wiper - 8'd1;
            end
            seq_phase = PH_DECIDE;
          end
        end
        default: begin
          tick_cnt  = '0;
          seq_phase = (tgt != wiper) ? PH_DECIDE : PH_IDLE;
        end
      endcase
    end
    moving = (seq_phase == PH_SETUP) || (seq_phase == PH_INC_LOW) ||
             (seq_phase == PH_INC_HIGH);
    pins.chip_select_n   = !moving;
    pins.up_down_level   = step_up;
    pins.increment_level = (seq_phase != PH_INC_LOW);
    pins.tap_position    = wiper;
    pins.busy_res        = moving || (target_tap() != wiper);
    return pins;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      regs.desired_tap     = DESIRED_TAP_RST;
      regs.dir_setup_ticks = DIR_SETUP_RST;
      regs.inc_low_ticks   = INC_LOW_RST;
      regs.inc_high_ticks  = INC_HIGH_RST;
      seq_phase            = PH_IDLE;
      tick_cnt             = '0;
      wiper                = (TAP_RESET > TAP_TOP) ? 8'(TAP_TOP) : 8'(TAP_RESET);
      step_up              = 1'b0;
      pin_levels_q.delete();
      leftover_done        = 1'b0;
      fail_count           = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[11:0]);
        if (pin_levels_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          want = pin_levels_q.pop_front();
          check_field("chip_select_n", 8'(want.chip_select_n), 8'(got.chip_select_n));
          check_field("up_down_level", 8'(want.up_down_level), 8'(got.up_down_level));
          check_field("increment_level", 8'(want.increment_level),
                      8'(got.increment_level));
          check_field("tap_position", want.tap_position, got.tap_position);
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        end
      end
      if (s_tvalid && s_tready) pin_levels_q.push_back(step_wiper_sequencer(s_tdata[0]));
      // register writes land after any tick taken on the same edge
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DESIRED_TAP: regs.desired_tap     = cfg_wdata[7:0];
          CFG_DIR_SETUP:   regs.dir_setup_ticks = cfg_wdata;
          CFG_INC_LOW:     regs.inc_low_ticks   = cfg_wdata;
          CFG_INC_HIGH:    regs.inc_high_ticks  = cfg_wdata;
          default: ;
        endcase
      end
      if (end_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (pin_levels_q.size() != 0) begin
          $error("%0d expected result transactions never arrived", pin_levels_q.size());
          fail_count++;
        end
      end
    end
  end

endmodule

/* sim/updown_pot_tap_stepper_top_tb.sv */
// ----------------------------------------------------------------------------
// updown_pot_tap_stepper_top_tb
// stimulus and verdict for the up/down potentiometer tap stepper
// ----------------------------------------------------------------------------
// Drives bursts of tick transactions, rewriting the target tap and the three
// phase lengths between bursts once every result has come back. A short
// directed opening covers zero-length phases, a step down in tap, the
// no-tick case and the register extremes; random bursts follow, mostly with
// short phases so that many full steps happen. Sender and receiver gaps
// change over the run, and the receiver stalls for long stretches to fill
// the block. The checker module does the prediction and comparison.
module updown_pot_tap_stepper_top_tb;
  import udp_pkg::*;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata   = '0;
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [15:0]              m_tdata;
  logic                     end_check = 1'b0;
  int                       fail_count;

  int ticks_sent    = 0;
  int results_taken = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 68;
  int hold_req      = 0;
  int hold_left     = 0;

  updown_pot_tap_stepper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  updown_pot_tap_stepper_chk i_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .end_check  (end_check),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) results_taken++;
  end

  task automatic send_tick(input logic tick_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, tick_val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic finish_burst();
    s_tvalid <= 1'b0;
    while (results_taken != ticks_sent) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] tap, input logic [15:0] setup,
                          input logic [15:0] low, input logic [15:0] high);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DESIRED_TAP;
    cfg_wdata <= {8'($urandom), tap};
    @(negedge clk);
    cfg_index <= CFG_DIR_SETUP;
    cfg_wdata <= setup;
    @(negedge clk);
    cfg_index <= CFG_INC_LOW;
    cfg_wdata <= low;
    @(negedge clk);
    cfg_index <= CFG_INC_HIGH;
    cfg_wdata <= high;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic tick_burst(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) send_tick($urandom_range(0, 99) < tick_pct);
    finish_burst();
  endtask

  function automatic logic [7:0] pick_tap();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly short phases so that whole steps fit in a burst
  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 29))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    int random_ticks;
    int burst_len;
    int holds_done;
    random_ticks = 0;
    holds_done   = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset target equals reset wiper, so ticks leave it idle
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    finish_burst();

    // zero-length phases act as one tick; some slots carry no tick
    set_regs(8'd130, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 12; i++) send_tick(i != 4 && i != 9);
    finish_burst();

    // target moved below the wiper, so the wiper steps down
    set_regs(8'd0, 16'd1, 16'd2, 16'd1);
    for (int i = 0; i < 6; i++) send_tick(1'b1);
    finish_burst();

    set_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_tick(1'b1);
    finish_burst();

    while (random_ticks < 550) begin
      if (random_ticks >= 370) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_ticks >= 185) begin
        send_idle_pct = 68;
        recv_idle_pct = 22;
      end
      set_regs(pick_tap(), pick_ticks(), pick_ticks(), pick_ticks());
      burst_len = $urandom_range(15, 45);
      if ((holds_done == 0 && random_ticks >= 90) ||
          (holds_done == 1 && random_ticks >= 400)) begin
        hold_req = 120;
        holds_done++;
      end
      tick_burst(burst_len, $urandom_range(60, 100));
      random_ticks += burst_len;
    end

    repeat (4) @(negedge clk);
    end_check <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
